FILE: rtl/slwq_pkg.sv
// shared constants and types for the sleep lock wait queue
package slwq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;
    localparam int MAX_RESULTS      = 16;
    localparam int RESULT_CNT_W     = $clog2(MAX_RESULTS);

    localparam int KIND_W   = 2;
    localparam int TASK_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [KIND_W-1:0] KIND_ACQUIRE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE_ONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE_ALL = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED       = 3'd0,
        ST_QUEUED        = 3'd1,
        ST_RELEASED      = 3'd2,
        ST_WOKEN         = 3'd3,
        ST_ALREADY_OWNER = 3'd4,
        ST_NOT_OWNER     = 3'd5,
        ST_QUEUE_FULL    = 3'd6
    } status_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

FILE: rtl/slwq_if.sv
// request and response channel interfaces
interface slwq_req_if;
    logic                        valid;
    logic                        ready;
    logic [slwq_pkg::KIND_W-1:0] kind;
    logic [slwq_pkg::TASK_W-1:0] task_id;

    modport source (output valid, kind, task_id, input ready);
    modport sink (input valid, kind, task_id, output ready);
endinterface

interface slwq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [slwq_pkg::STATUS_W-1:0] status;
    logic [slwq_pkg::TASK_W-1:0]   result_task;
    logic                          lock_held;
    logic                          last;

    modport source (output valid, status, result_task, lock_held, last, input ready);
    modport sink (input valid, status, result_task, lock_held, last, output ready);
endinterface

FILE: rtl/sleep_lock_wait_queue.sv
// top level of the sleep lock unit with its queue of waiting tasks
//
//   channel  modport  handshake     payload
//   req      sink     valid/ready   kind, task_id
//   rsp      source   valid/ready   status, result_task, lock_held, last
//
// acquire, refused and plain release requests: accepted into a register, then decided against the lock
// release with waiters: accept, start the queue read, then one woken task per cycle while rsp does not stall,
//   paced by the single registered read port of the waiter queue memory
// one request at a time; the next is taken once the last response is in the output register
// rsp stalls hold the output register and the queue read; no clearing pass after reset
module sleep_lock_wait_queue #(
    parameter int QUEUE_DEPTH  = slwq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = slwq_pkg::TASK_ID_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    slwq_req_if.sink   req,
    slwq_rsp_if.source rsp
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    slwq_pkg::mem_ctl_t      mem_ctl;
    logic [PW-1:0]           wr_addr;
    logic [TASK_ID_BITS-1:0] wr_data;
    logic [PW-1:0]           rd_addr;
    logic [TASK_ID_BITS-1:0] rd_data;

    slwq_ctrl #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slwq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TASK_ID_BITS)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

FILE: rtl/slwq_mem.sv
// waiter queue storage, one write and one registered read port
module slwq_mem #(
    parameter int DEPTH = slwq_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = slwq_pkg::TASK_ID_BITS_DEF
) (
    input  logic                                          clk,
    input  slwq_pkg::mem_ctl_t                            ctl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/slwq_ctrl.sv
// lock state, queue pointers, request sequencer and response register
module slwq_ctrl #(
    parameter int QUEUE_DEPTH  = slwq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = slwq_pkg::TASK_ID_BITS_DEF
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    slwq_req_if.sink                                                  req,
    slwq_rsp_if.source                                                rsp,
    output slwq_pkg::mem_ctl_t                                        mem_ctl,
    output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr,
    output logic [TASK_ID_BITS-1:0]                                   wr_data,
    output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
    input  logic [TASK_ID_BITS-1:0]                                   rd_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = TASK_ID_BITS;
    localparam int NW = slwq_pkg::RESULT_CNT_W;
    localparam int FW = slwq_pkg::TASK_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WAKE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [slwq_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [TW-1:0]               task_reg, task_next;
    logic                        lock_reg, lock_next;
    logic [TW-1:0]               owner_reg, owner_next;
    logic [PW-1:0]               head_reg, head_next;
    logic [PW-1:0]               tail_reg, tail_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [NW-1:0]               n_reg, n_next;

    logic                        out_valid_reg, out_valid_next;
    slwq_pkg::status_t           out_status_reg, out_status_next;
    logic [FW-1:0]               out_task_reg, out_task_next;
    logic                        out_held_reg, out_held_next;
    logic                        out_last_reg, out_last_next;

    logic                        slot_free;
    logic                        is_owner;
    logic                        wake_last;
    logic [TW+FW-1:0]            task_in_wide;
    logic [TW+FW-1:0]            task_out_wide;
    logic                        emit;
    slwq_pkg::status_t           e_status;
    logic [TW-1:0]               e_task;
    logic                        e_held;
    logic                        e_last;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign slot_free     = !out_valid_reg || rsp.ready;
    assign is_owner      = lock_reg && (owner_reg == task_reg);
    assign wake_last     = (kind_reg == slwq_pkg::KIND_RELEASE_ONE) ||
                           (count_reg == CW'(1)) ||
                           (n_reg == NW'(slwq_pkg::MAX_RESULTS - 1));
    assign task_in_wide  = {{TW{1'b0}}, req.task_id};
    assign task_out_wide = {{FW{1'b0}}, e_task};

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.result_task = out_task_reg;
    assign rsp.lock_held   = out_held_reg;
    assign rsp.last        = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        task_next  = task_reg;
        lock_next  = lock_reg;
        owner_next = owner_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        n_next     = n_reg;
        mem_ctl    = '0;
        wr_addr    = tail_reg;
        wr_data    = task_reg;
        rd_addr    = head_reg;
        emit       = 1'b0;
        e_status   = slwq_pkg::ST_GRANTED;
        e_task     = task_reg;
        e_held     = 1'b1;
        e_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    task_next  = task_in_wide[TW-1:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (kind_reg == slwq_pkg::KIND_ACQUIRE)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        priority if (is_owner)
                        begin
                            e_status = slwq_pkg::ST_ALREADY_OWNER;
                        end
                        else if (!lock_reg)
                        begin
                            e_status   = slwq_pkg::ST_GRANTED;
                            lock_next  = 1'b1;
                            owner_next = task_reg;
                        end
                        else if (count_reg < CW'(QUEUE_DEPTH))
                        begin
                            e_status      = slwq_pkg::ST_QUEUED;
                            mem_ctl.wr_en = 1'b1;
                            tail_next     = ptr_inc(tail_reg);
                            count_next    = count_reg + CW'(1);
                        end
                        else
                        begin
                            e_status = slwq_pkg::ST_QUEUE_FULL;
                        end
                    end
                end
                else if (kind_reg == slwq_pkg::KIND_RELEASE_ONE ||
                         kind_reg == slwq_pkg::KIND_RELEASE_ALL)
                begin
                    priority if (!is_owner)
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            e_status   = slwq_pkg::ST_NOT_OWNER;
                            e_held     = lock_reg;
                            state_next = S_IDLE;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            e_status   = slwq_pkg::ST_RELEASED;
                            e_held     = 1'b0;
                            lock_next  = 1'b0;
                            owner_next = '0;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        lock_next     = 1'b0;
                        owner_next    = '0;
                        mem_ctl.rd_en = 1'b1;
                        n_next        = '0;
                        state_next    = S_WAKE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WAKE:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_status   = slwq_pkg::ST_WOKEN;
                    e_task     = rd_data;
                    e_held     = 1'b0;
                    e_last     = wake_last;
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - CW'(1);
                    n_next     = n_reg + NW'(1);
                    if (wake_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = ptr_inc(head_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        out_held_next   = out_held_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = e_status;
            out_task_next   = task_out_wide[FW-1:0];
            out_held_next   = e_held;
            out_last_next   = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lock_reg      <= 1'b0;
            owner_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lock_reg      <= lock_next;
            owner_reg     <= owner_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        task_reg       <= task_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
        out_held_reg   <= out_held_next;
        out_last_reg   <= out_last_next;
    end

endmodule
